[src/euler_to_basis_vectors_defines.svh]
// ----------------------------------------------------------------------------
// euler_to_basis_vectors assertion macros
// shared property wrappers for the block checker
// ----------------------------------------------------------------------------
`ifndef EULER_TO_BASIS_VECTORS_DEFINES_SVH
`define EULER_TO_BASIS_VECTORS_DEFINES_SVH

// clocked property with reset disable
`define ETBV_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("etbv assertion failed");

// q1.14 unit range on a valid beat
`define ETBV_ASSERT_UNIT(lbl, clk, rst_n, en, v) \
    `ETBV_ASSERT(lbl, clk, rst_n, en |-> ((v <= 16'sd16384) && (v >= -16'sd16384)))

`endif

[src/etbv_pkg.sv]
// ----------------------------------------------------------------------------
// etbv_pkg
// types, constants and tables for the euler angle to basis vector block
// ----------------------------------------------------------------------------
package etbv_pkg;

    localparam int ANGLE_W      = 16;
    localparam int IN_W         = 17;
    localparam int OUT_W        = 16;
    localparam int VAL_W        = 32;
    localparam int FULL_TURN    = 46080;
    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_ENTRIES = 24;
    localparam int ROT_STEPS    = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
    localparam int STEP_W       = $clog2(ATAN_ENTRIES);
    localparam int WRAP_W       = 18;
    localparam int WRAP_BIAS    = 2 * FULL_TURN;
    localparam int QUO_W        = 10;
    localparam int REM_W        = 6;
    localparam int FRAC_W       = 22;
    localparam int RECIP_45     = 46604;
    localparam int RECIP_SH     = 21;
    localparam int MUL_STEPS    = 15;
    localparam int MSTEP_W      = $clog2(MUL_STEPS);
    localparam int ONE_Q14      = 16384;

    localparam logic signed [VAL_W-1:0] CORDIC_GAIN = 32'sd652032874;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    typedef struct packed {
        logic [ANGLE_W-1:0] pitch;
        logic [ANGLE_W-1:0] yaw;
        logic [ANGLE_W-1:0] roll;
    } angles_t;

    typedef enum logic [1:0] {
        ANG_PITCH,
        ANG_YAW,
        ANG_ROLL
    } ang_sel_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_DIVQ,
        B_TURN,
        B_ROT,
        B_QUAD,
        B_MULA,
        B_MULB,
        B_OUT
    } back_state_t;

    typedef enum logic [3:0] {
        S_SP, S_CP, S_SY, S_CY, S_SR, S_CR, S_FX, S_FZ, S_RX, S_RY, S_RZ, S_TMP
    } src_t;

    typedef enum logic [3:0] {
        D_FX, D_FZ, D_RX, D_RY, D_RZ, D_TMP, D_UX, D_UY, D_UZ
    } dst_t;

    typedef enum logic [1:0] {
        M_SET, M_NEG, M_ADD, M_SUB
    } mop_t;

    typedef struct packed {
        src_t a;
        src_t b;
        dst_t d;
        mop_t op;
    } mul_op_t;

    function automatic mul_op_t mul_prog(input logic [MSTEP_W-1:0] s);
        mul_op_t m;
        begin
            case (s)
                4'd0:    m = '{S_SY,  S_CP,  D_FX,  M_NEG};
                4'd1:    m = '{S_CY,  S_CP,  D_FZ,  M_NEG};
                4'd2:    m = '{S_CY,  S_CR,  D_RX,  M_SET};
                4'd3:    m = '{S_SY,  S_SP,  D_TMP, M_SET};
                4'd4:    m = '{S_TMP, S_SR,  D_RX,  M_ADD};
                4'd5:    m = '{S_CP,  S_SR,  D_RY,  M_SET};
                4'd6:    m = '{S_SP,  S_SR,  D_TMP, M_SET};
                4'd7:    m = '{S_CY,  S_TMP, D_RZ,  M_SET};
                4'd8:    m = '{S_SY,  S_CR,  D_RZ,  M_SUB};
                4'd9:    m = '{S_RY,  S_FZ,  D_UX,  M_SET};
                4'd10:   m = '{S_RZ,  S_SP,  D_UX,  M_SUB};
                4'd11:   m = '{S_RZ,  S_FX,  D_UY,  M_SET};
                4'd12:   m = '{S_RX,  S_FZ,  D_UY,  M_SUB};
                4'd13:   m = '{S_RX,  S_SP,  D_UZ,  M_SET};
                4'd14:   m = '{S_RY,  S_FX,  D_UZ,  M_SUB};
                default: m = '{S_SP,  S_SP,  D_TMP, M_SET};
            endcase
            return m;
        end
    endfunction

    // atan(2^-i) as a fraction of a full turn, 2^32 per turn
    function automatic logic signed [VAL_W-1:0] atan_turn(input logic [STEP_W-1:0] i);
        logic signed [VAL_W-1:0] v;
        begin
            case (i)
                5'd0:    v = 32'sd536870912;
                5'd1:    v = 32'sd316933406;
                5'd2:    v = 32'sd167458907;
                5'd3:    v = 32'sd85004756;
                5'd4:    v = 32'sd42667331;
                5'd5:    v = 32'sd21354465;
                5'd6:    v = 32'sd10679838;
                5'd7:    v = 32'sd5340245;
                5'd8:    v = 32'sd2670163;
                5'd9:    v = 32'sd1335087;
                5'd10:   v = 32'sd667544;
                5'd11:   v = 32'sd333772;
                5'd12:   v = 32'sd166886;
                5'd13:   v = 32'sd83443;
                5'd14:   v = 32'sd41722;
                5'd15:   v = 32'sd20861;
                5'd16:   v = 32'sd10430;
                5'd17:   v = 32'sd5215;
                5'd18:   v = 32'sd2608;
                5'd19:   v = 32'sd1304;
                5'd20:   v = 32'sd652;
                5'd21:   v = 32'sd326;
                5'd22:   v = 32'sd163;
                5'd23:   v = 32'sd81;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

    // floor(r * 2^22 / 45) for a remainder below 45
    function automatic logic [FRAC_W-1:0] rem_turn(input logic [REM_W-1:0] r);
        logic [FRAC_W-1:0] v;
        begin
            case (r)
                6'd0:    v = 22'd0;
                6'd1:    v = 22'd93206;
                6'd2:    v = 22'd186413;
                6'd3:    v = 22'd279620;
                6'd4:    v = 22'd372827;
                6'd5:    v = 22'd466033;
                6'd6:    v = 22'd559240;
                6'd7:    v = 22'd652447;
                6'd8:    v = 22'd745654;
                6'd9:    v = 22'd838860;
                6'd10:   v = 22'd932067;
                6'd11:   v = 22'd1025274;
                6'd12:   v = 22'd1118481;
                6'd13:   v = 22'd1211687;
                6'd14:   v = 22'd1304894;
                6'd15:   v = 22'd1398101;
                6'd16:   v = 22'd1491308;
                6'd17:   v = 22'd1584514;
                6'd18:   v = 22'd1677721;
                6'd19:   v = 22'd1770928;
                6'd20:   v = 22'd1864135;
                6'd21:   v = 22'd1957341;
                6'd22:   v = 22'd2050548;
                6'd23:   v = 22'd2143755;
                6'd24:   v = 22'd2236962;
                6'd25:   v = 22'd2330168;
                6'd26:   v = 22'd2423375;
                6'd27:   v = 22'd2516582;
                6'd28:   v = 22'd2609789;
                6'd29:   v = 22'd2702995;
                6'd30:   v = 22'd2796202;
                6'd31:   v = 22'd2889409;
                6'd32:   v = 22'd2982616;
                6'd33:   v = 22'd3075822;
                6'd34:   v = 22'd3169029;
                6'd35:   v = 22'd3262236;
                6'd36:   v = 22'd3355443;
                6'd37:   v = 22'd3448649;
                6'd38:   v = 22'd3541856;
                6'd39:   v = 22'd3635063;
                6'd40:   v = 22'd3728270;
                6'd41:   v = 22'd3821476;
                6'd42:   v = 22'd3914683;
                6'd43:   v = 22'd4007890;
                6'd44:   v = 22'd4101097;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

    // biased non-negative sum reduced into one turn
    function automatic logic [ANGLE_W-1:0] wrap_turn(input logic [WRAP_W-1:0] v);
        logic [WRAP_W-1:0] w;
        begin
            w = v;
            for (int k = 0; k < 4; k++)
            begin
                if (w >= WRAP_W'(FULL_TURN))
                begin
                    w = w - WRAP_W'(FULL_TURN);
                end
            end
            return w[ANGLE_W-1:0];
        end
    endfunction

    // q2.30 to q1.14 with rounding and saturation
    function automatic logic signed [OUT_W-1:0] to_q14(input logic signed [VAL_W-1:0] v);
        logic signed [VAL_W:0]    s;
        logic signed [VAL_W-16:0] r;
        logic signed [OUT_W-1:0]  q;
        begin
            s = {v[VAL_W-1], v} + 33'sd32768;
            r = s[VAL_W:16];
            if (r > 17'sd16384)
            begin
                q = 16'sd16384;
            end
            else if (r < -17'sd16384)
            begin
                q = -16'sd16384;
            end
            else
            begin
                q = r[OUT_W-1:0];
            end
            return q;
        end
    endfunction

endpackage

[src/etbv_if.sv]
// ----------------------------------------------------------------------------
// etbv channel interfaces
// command and result channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface etbv_cmd_if;
    logic                                valid;
    logic                                ready;
    logic                                kind;
    logic signed [etbv_pkg::IN_W-1:0]    angle_x;
    logic signed [etbv_pkg::IN_W-1:0]    angle_y;
    logic signed [etbv_pkg::IN_W-1:0]    angle_z;

    modport source (output valid, kind, angle_x, angle_y, angle_z, input ready);
    modport sink (input valid, kind, angle_x, angle_y, angle_z, output ready);
endinterface

interface etbv_res_if;
    logic                                valid;
    logic                                ready;
    logic signed [etbv_pkg::OUT_W-1:0]   forward_x;
    logic signed [etbv_pkg::OUT_W-1:0]   forward_y;
    logic signed [etbv_pkg::OUT_W-1:0]   forward_z;
    logic signed [etbv_pkg::OUT_W-1:0]   right_x;
    logic signed [etbv_pkg::OUT_W-1:0]   right_y;
    logic signed [etbv_pkg::OUT_W-1:0]   right_z;
    logic signed [etbv_pkg::OUT_W-1:0]   up_x;
    logic signed [etbv_pkg::OUT_W-1:0]   up_y;
    logic signed [etbv_pkg::OUT_W-1:0]   up_z;

    modport source (output valid, forward_x, forward_y, forward_z, right_x, right_y,
                    right_z, up_x, up_y, up_z, input ready);
    modport sink (input valid, forward_x, forward_y, forward_z, right_x, right_y,
                  right_z, up_x, up_y, up_z, output ready);
endinterface

[src/etbv_queue.sv]
// ----------------------------------------------------------------------------
// etbv_queue
// two-entry queue of wrapped angle sets between front and back
// ----------------------------------------------------------------------------
module etbv_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  etbv_pkg::angles_t  push_data,
    output logic               full,
    input  logic               pop,
    output logic               not_empty,
    output etbv_pkg::angles_t  pop_data
);

    etbv_pkg::angles_t mem_reg [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        count_reg;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

[src/etbv_front.sv]
// ----------------------------------------------------------------------------
// etbv_front
// accepts commands, replaces or adds the angles and wraps them into one turn
// ----------------------------------------------------------------------------
module etbv_front
(
    input  logic               clk,
    input  logic               rst_n,
    etbv_cmd_if.sink           cmd,
    input  logic               q_full,
    output logic               q_push,
    output etbv_pkg::angles_t  q_data
);

    etbv_pkg::angles_t stored_reg;
    etbv_pkg::angles_t base;

    function automatic logic [etbv_pkg::ANGLE_W-1:0] next_angle(
        input logic [etbv_pkg::ANGLE_W-1:0]    b,
        input logic signed [etbv_pkg::IN_W-1:0] d
    );
        logic signed [etbv_pkg::WRAP_W:0] s;
        begin
            s = $signed({3'b000, b}) + {{2{d[etbv_pkg::IN_W-1]}}, d}
                + (etbv_pkg::WRAP_W + 1)'(etbv_pkg::WRAP_BIAS);
            return etbv_pkg::wrap_turn(s[etbv_pkg::WRAP_W-1:0]);
        end
    endfunction

    assign cmd.ready = !q_full;
    assign q_push    = cmd.valid && !q_full;
    assign base      = cmd.kind ? stored_reg : '0;

    always_comb
    begin
        q_data.pitch = next_angle(base.pitch, cmd.angle_x);
        q_data.yaw   = next_angle(base.yaw, cmd.angle_y);
        q_data.roll  = next_angle(base.roll, cmd.angle_z);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stored_reg <= '0;
        end
        else if (q_push)
        begin
            stored_reg <= q_data;
        end
    end

endmodule

[src/etbv_back.sv]
// ----------------------------------------------------------------------------
// etbv_back
// shared cordic for the three angles, then a shared multiplier sequence
// that builds forward, right and up, and the result register
// ----------------------------------------------------------------------------
module etbv_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  etbv_pkg::angles_t  q_data,
    output logic               q_pop,
    etbv_res_if.source         res
);

    localparam int VW = etbv_pkg::VAL_W;

    etbv_pkg::back_state_t state_reg, state_next;

    etbv_pkg::angles_t               angles_reg;
    etbv_pkg::ang_sel_t              sel_reg;
    logic [etbv_pkg::STEP_W-1:0]     step_reg;
    logic [etbv_pkg::MSTEP_W-1:0]    mstep_reg;
    logic [etbv_pkg::QUO_W-1:0]      quo_reg;
    logic [1:0]                      quad_reg;
    logic signed [VW-1:0]            x_reg, y_reg, z_reg;
    logic signed [VW-1:0]            sp_reg, cp_reg, sy_reg, cy_reg, sr_reg, cr_reg;
    logic signed [VW-1:0]            fx_reg, fz_reg, rx_reg, ry_reg, rz_reg, tmp_reg;
    logic signed [VW-1:0]            ux_reg, uy_reg, uz_reg;
    logic signed [2*VW-1:0]          prod_reg;
    logic                            res_valid_reg;
    logic signed [etbv_pkg::OUT_W-1:0] fwd_x_reg, fwd_y_reg, fwd_z_reg;
    logic signed [etbv_pkg::OUT_W-1:0] rgt_x_reg, rgt_y_reg, rgt_z_reg;
    logic signed [etbv_pkg::OUT_W-1:0] up_x_reg, up_y_reg, up_z_reg;

    logic [etbv_pkg::ANGLE_W-1:0]    ang;
    logic [2*etbv_pkg::ANGLE_W-1:0]  quo_prod;
    logic [etbv_pkg::ANGLE_W-1:0]    quo_x45;
    logic [etbv_pkg::ANGLE_W-1:0]    rem_full;
    logic [VW-1:0]                   turn;
    logic signed [VW-1:0]            dx, dy, cs, sn;
    etbv_pkg::mul_op_t               mop;
    logic signed [VW-1:0]            opa, opb, rnd, dst_old, dst_new;
    logic signed [2*VW-1:0]          prod_rnd;
    logic                            load_out;
    logic                            rot_last;

    always_comb
    begin
        case (sel_reg)
            etbv_pkg::ANG_PITCH: ang = angles_reg.pitch;
            etbv_pkg::ANG_YAW:   ang = angles_reg.yaw;
            etbv_pkg::ANG_ROLL:  ang = angles_reg.roll;
            default:             ang = angles_reg.pitch;
        endcase
    end

    // angle / 45 by reciprocal, remainder through a table
    assign quo_prod = ang * etbv_pkg::ANGLE_W'(etbv_pkg::RECIP_45);
    assign quo_x45  = {1'b0, quo_reg, 5'b0} + {3'b0, quo_reg, 3'b0}
                      + {4'b0, quo_reg, 2'b0} + {6'b0, quo_reg};
    assign rem_full = ang - quo_x45;
    assign turn     = {quo_reg, etbv_pkg::rem_turn(rem_full[etbv_pkg::REM_W-1:0])};

    assign dx       = y_reg >>> step_reg;
    assign dy       = x_reg >>> step_reg;
    assign rot_last = (step_reg == etbv_pkg::STEP_W'(etbv_pkg::ROT_STEPS - 1));

    always_comb
    begin
        case (quad_reg)
            etbv_pkg::QUAD_0: begin cs = x_reg;  sn = y_reg;  end
            etbv_pkg::QUAD_1: begin cs = -y_reg; sn = x_reg;  end
            etbv_pkg::QUAD_2: begin cs = -x_reg; sn = -y_reg; end
            default:          begin cs = y_reg;  sn = -x_reg; end
        endcase
    end

    function automatic logic signed [VW-1:0] pick(
        input etbv_pkg::src_t s,
        input logic signed [VW-1:0] sp, cp, sy, cy, sr, cr,
        input logic signed [VW-1:0] fx, fz, rx, ry, rz, tm
    );
        logic signed [VW-1:0] v;
        begin
            case (s)
                etbv_pkg::S_SP:  v = sp;
                etbv_pkg::S_CP:  v = cp;
                etbv_pkg::S_SY:  v = sy;
                etbv_pkg::S_CY:  v = cy;
                etbv_pkg::S_SR:  v = sr;
                etbv_pkg::S_CR:  v = cr;
                etbv_pkg::S_FX:  v = fx;
                etbv_pkg::S_FZ:  v = fz;
                etbv_pkg::S_RX:  v = rx;
                etbv_pkg::S_RY:  v = ry;
                etbv_pkg::S_RZ:  v = rz;
                etbv_pkg::S_TMP: v = tm;
                default:         v = '0;
            endcase
            return v;
        end
    endfunction

    assign mop = etbv_pkg::mul_prog(mstep_reg);
    assign opa = pick(mop.a, sp_reg, cp_reg, sy_reg, cy_reg, sr_reg, cr_reg,
                      fx_reg, fz_reg, rx_reg, ry_reg, rz_reg, tmp_reg);
    assign opb = pick(mop.b, sp_reg, cp_reg, sy_reg, cy_reg, sr_reg, cr_reg,
                      fx_reg, fz_reg, rx_reg, ry_reg, rz_reg, tmp_reg);

    assign prod_rnd = prod_reg + (2*VW)'(64'sd536870912);
    assign rnd      = prod_rnd[VW+29:30];

    always_comb
    begin
        case (mop.d)
            etbv_pkg::D_FX:  dst_old = fx_reg;
            etbv_pkg::D_FZ:  dst_old = fz_reg;
            etbv_pkg::D_RX:  dst_old = rx_reg;
            etbv_pkg::D_RY:  dst_old = ry_reg;
            etbv_pkg::D_RZ:  dst_old = rz_reg;
            etbv_pkg::D_TMP: dst_old = tmp_reg;
            etbv_pkg::D_UX:  dst_old = ux_reg;
            etbv_pkg::D_UY:  dst_old = uy_reg;
            etbv_pkg::D_UZ:  dst_old = uz_reg;
            default:         dst_old = '0;
        endcase
        case (mop.op)
            etbv_pkg::M_SET: dst_new = rnd;
            etbv_pkg::M_NEG: dst_new = -rnd;
            etbv_pkg::M_ADD: dst_new = dst_old + rnd;
            etbv_pkg::M_SUB: dst_new = dst_old - rnd;
            default:         dst_new = rnd;
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            etbv_pkg::B_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    state_next = etbv_pkg::B_DIVQ;
                end
            end
            etbv_pkg::B_DIVQ: state_next = etbv_pkg::B_TURN;
            etbv_pkg::B_TURN: state_next = etbv_pkg::B_ROT;
            etbv_pkg::B_ROT:
            begin
                if (rot_last)
                begin
                    state_next = etbv_pkg::B_QUAD;
                end
            end
            etbv_pkg::B_QUAD:
            begin
                state_next = (sel_reg == etbv_pkg::ANG_ROLL) ? etbv_pkg::B_MULA
                                                             : etbv_pkg::B_DIVQ;
            end
            etbv_pkg::B_MULA: state_next = etbv_pkg::B_MULB;
            etbv_pkg::B_MULB:
            begin
                state_next = (mstep_reg == etbv_pkg::MSTEP_W'(etbv_pkg::MUL_STEPS - 1))
                             ? etbv_pkg::B_OUT : etbv_pkg::B_MULA;
            end
            etbv_pkg::B_OUT:
            begin
                if (!res_valid_reg || res.ready)
                begin
                    load_out   = 1'b1;
                    state_next = etbv_pkg::B_IDLE;
                end
            end
            default: state_next = etbv_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= etbv_pkg::B_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            etbv_pkg::B_IDLE:
            begin
                angles_reg <= q_data;
                sel_reg    <= etbv_pkg::ANG_PITCH;
                mstep_reg  <= '0;
            end
            etbv_pkg::B_DIVQ:
            begin
                quo_reg <= quo_prod[etbv_pkg::RECIP_SH +: etbv_pkg::QUO_W];
            end
            etbv_pkg::B_TURN:
            begin
                quad_reg <= turn[VW-1:VW-2];
                z_reg    <= $signed({2'b00, turn[VW-3:0]});
                x_reg    <= etbv_pkg::CORDIC_GAIN;
                y_reg    <= '0;
                step_reg <= '0;
            end
            etbv_pkg::B_ROT:
            begin
                if (!z_reg[VW-1])
                begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - etbv_pkg::atan_turn(step_reg);
                end
                else
                begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + etbv_pkg::atan_turn(step_reg);
                end
                step_reg <= step_reg + etbv_pkg::STEP_W'(1);
            end
            etbv_pkg::B_QUAD:
            begin
                case (sel_reg)
                    etbv_pkg::ANG_PITCH:
                    begin
                        sp_reg  <= sn;
                        cp_reg  <= cs;
                        sel_reg <= etbv_pkg::ANG_YAW;
                    end
                    etbv_pkg::ANG_YAW:
                    begin
                        sy_reg  <= sn;
                        cy_reg  <= cs;
                        sel_reg <= etbv_pkg::ANG_ROLL;
                    end
                    default:
                    begin
                        sr_reg <= sn;
                        cr_reg <= cs;
                    end
                endcase
            end
            etbv_pkg::B_MULA:
            begin
                prod_reg <= opa * opb;
            end
            etbv_pkg::B_MULB:
            begin
                case (mop.d)
                    etbv_pkg::D_FX:  fx_reg  <= dst_new;
                    etbv_pkg::D_FZ:  fz_reg  <= dst_new;
                    etbv_pkg::D_RX:  rx_reg  <= dst_new;
                    etbv_pkg::D_RY:  ry_reg  <= dst_new;
                    etbv_pkg::D_RZ:  rz_reg  <= dst_new;
                    etbv_pkg::D_TMP: tmp_reg <= dst_new;
                    etbv_pkg::D_UX:  ux_reg  <= dst_new;
                    etbv_pkg::D_UY:  uy_reg  <= dst_new;
                    default:         uz_reg  <= dst_new;
                endcase
                mstep_reg <= mstep_reg + etbv_pkg::MSTEP_W'(1);
            end
            default:
            begin
                if (load_out)
                begin
                    fwd_x_reg <= etbv_pkg::to_q14(fx_reg);
                    fwd_y_reg <= etbv_pkg::to_q14(sp_reg);
                    fwd_z_reg <= etbv_pkg::to_q14(fz_reg);
                    rgt_x_reg <= etbv_pkg::to_q14(rx_reg);
                    rgt_y_reg <= etbv_pkg::to_q14(ry_reg);
                    rgt_z_reg <= etbv_pkg::to_q14(rz_reg);
                    up_x_reg  <= etbv_pkg::to_q14(ux_reg);
                    up_y_reg  <= etbv_pkg::to_q14(uy_reg);
                    up_z_reg  <= etbv_pkg::to_q14(uz_reg);
                end
            end
        endcase
    end

    assign res.valid     = res_valid_reg;
    assign res.forward_x = fwd_x_reg;
    assign res.forward_y = fwd_y_reg;
    assign res.forward_z = fwd_z_reg;
    assign res.right_x   = rgt_x_reg;
    assign res.right_y   = rgt_y_reg;
    assign res.right_z   = rgt_z_reg;
    assign res.up_x      = up_x_reg;
    assign res.up_y      = up_y_reg;
    assign res.up_z      = up_z_reg;

endmodule

[src/euler_to_basis_vectors.sv]
// per angle a divide, a turn step, 16 steps on the shared cordic and a quadrant
// fix, then 15 products on one shared 32x32 multiplier, each a multiply and a
// write-back; one item in the back at a time, two commands queue behind it
// reset: asynchronous active low, stored angles cleared to zero, queue emptied
// ----------------------------------------------------------------------------
// euler_to_basis_vectors
// yaw-pitch-roll euler angles to forward, right and up vectors in q1.14
// ----------------------------------------------------------------------------
module euler_to_basis_vectors
(
    input  logic        clk,
    input  logic        rst_n,
    etbv_cmd_if.sink    cmd,
    etbv_res_if.source  res
);

    logic              q_full;
    logic              q_push;
    logic              q_pop;
    logic              q_not_empty;
    etbv_pkg::angles_t q_in;
    etbv_pkg::angles_t q_out;

    etbv_front u_front
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (q_in)
    );

    etbv_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_out)
    );

    etbv_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_not_empty),
        .q_data  (q_out),
        .q_pop   (q_pop),
        .res     (res)
    );

endmodule

[src/etbv_checker.sv]
// ----------------------------------------------------------------------------
// etbv_checker
// port-level checks on the result channel of euler_to_basis_vectors
// ----------------------------------------------------------------------------
`include "euler_to_basis_vectors_defines.svh"

module etbv_checker
(
    input logic                                clk,
    input logic                                rst_n,
    input logic                                res_valid,
    input logic                                res_ready,
    input logic signed [etbv_pkg::OUT_W-1:0]   forward_x,
    input logic signed [etbv_pkg::OUT_W-1:0]   right_y,
    input logic signed [etbv_pkg::OUT_W-1:0]   up_z
);

    // stalled result beat holds
    `ETBV_ASSERT(a_res_hold, clk, rst_n, res_valid && !res_ready |=> res_valid && $stable(forward_x))

    `ETBV_ASSERT_UNIT(a_fwd_unit, clk, rst_n, res_valid, forward_x)
    `ETBV_ASSERT_UNIT(a_right_unit, clk, rst_n, res_valid, right_y)
    `ETBV_ASSERT_UNIT(a_up_unit, clk, rst_n, res_valid, up_z)

endmodule

bind euler_to_basis_vectors etbv_checker u_etbv_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .forward_x (res.forward_x),
    .right_y   (res.right_y),
    .up_z      (res.up_z)
);
